>>> hdl/dmx_channel_crossfade_assert.svh
// Assertion macros for the crossfade engine.
// Used by the top level; no dependencies.
`ifndef DMX_CHANNEL_CROSSFADE_ASSERT_SVH
`define DMX_CHANNEL_CROSSFADE_ASSERT_SVH
`ifndef SYNTHESIS
`define DCF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DCF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DCF_ASSERT(lbl, clk, rst, prop, msg)
`define DCF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/dcf_pkg.sv
// Shared types and constants for the crossfade engine.
// No dependencies.
package dcf_pkg;
   localparam int CHAN_BITS   = 9;
   localparam int LEVEL_BITS  = 8;
   localparam int UNIV_BITS   = 8;
   localparam int STATUS_BITS = 18;
   localparam int PORT_TIME_BITS = 32;
   localparam int DIV_STEPS   = 8;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_EVAL  = 1'b1;

   typedef struct packed {
      logic                  kind;
      logic                  in_range;
      logic [CHAN_BITS-1:0]  channel;
      logic [LEVEL_BITS-1:0] target;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_EVAL, ST_DIV, ST_FIN, ST_EMIT
   } back_state_type;
endpackage

>>> hdl/dcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

>>> hdl/dcf_front.sv
// Front end: accepts input words, drops out-of-range writes, queues the rest.
// Depends on dcf_pkg.
module dcf_front #(
   parameter int CHANNELS  = 512,
   parameter int TIME_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clearing,
   input  logic                                  req_push,
   output logic                                  req_full,
   input  logic                                  req_kind,
   input  logic [dcf_pkg::CHAN_BITS-1:0]         req_channel,
   input  logic [dcf_pkg::LEVEL_BITS-1:0]        req_target_level,
   input  logic [dcf_pkg::PORT_TIME_BITS-1:0]    req_fade_begin,
   input  logic [dcf_pkg::PORT_TIME_BITS-1:0]    req_fade_finish,
   input  logic [dcf_pkg::PORT_TIME_BITS-1:0]    req_now_time,
   output logic                                  cmd_valid,
   input  logic                                  cmd_ready,
   output dcf_pkg::cmd_type                      cmd,
   output logic [TIME_BITS-1:0]                  cmd_begin,
   output logic [TIME_BITS-1:0]                  cmd_finish,
   output logic [TIME_BITS-1:0]                  cmd_now
);
   localparam int WIDE = 64 + dcf_pkg::PORT_TIME_BITS;

   dcf_pkg::cmd_type     q_cmd_ff    [2];
   logic [TIME_BITS-1:0] q_begin_ff  [2];
   logic [TIME_BITS-1:0] q_finish_ff [2];
   logic [TIME_BITS-1:0] q_now_ff    [2];
   logic                 wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 accept, enq, deq, in_range;
   logic [WIDE-1:0]      wide_begin, wide_finish, wide_now;
   dcf_pkg::cmd_type     new_cmd;

   assign wide_begin  = {64'd0, req_fade_begin};
   assign wide_finish = {64'd0, req_fade_finish};
   assign wide_now    = {64'd0, req_now_time};

   assign in_range = ({1'b0, req_channel} < 10'(CHANNELS));
   assign req_full = (count_ff == 2'd2) || clearing;
   assign accept   = req_push && !req_full;
   assign enq      = accept && (in_range || (req_kind == dcf_pkg::KIND_EVAL));
   assign cmd_valid = (count_ff != 2'd0);
   assign deq      = cmd_valid && cmd_ready;

   always_comb begin
      new_cmd.kind     = req_kind;
      new_cmd.in_range = in_range;
      new_cmd.channel  = req_channel;
      new_cmd.target   = req_target_level;
      wr_ptr_in = enq ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = deq ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, enq} - {1'b0, deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_cmd_ff[wr_ptr_ff]    <= new_cmd;
         q_begin_ff[wr_ptr_ff]  <= wide_begin[TIME_BITS-1:0];
         q_finish_ff[wr_ptr_ff] <= wide_finish[TIME_BITS-1:0];
         q_now_ff[wr_ptr_ff]    <= wide_now[TIME_BITS-1:0];
      end
   end

   assign cmd        = q_cmd_ff[rd_ptr_ff];
   assign cmd_begin  = q_begin_ff[rd_ptr_ff];
   assign cmd_finish = q_finish_ff[rd_ptr_ff];
   assign cmd_now    = q_now_ff[rd_ptr_ff];
endmodule

>>> hdl/dcf_back.sv
// Back end: clears channel state, stores writes, evaluates fades with a
// bit-serial divider, holds one result word. Depends on dcf_pkg and dcf_ram.
module dcf_back #(
   parameter int CHANNELS  = 512,
   parameter int TIME_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   output logic                                 clearing,
   input  logic                                 cmd_valid,
   output logic                                 cmd_ready,
   input  dcf_pkg::cmd_type                     cmd,
   input  logic [TIME_BITS-1:0]                 cmd_begin,
   input  logic [TIME_BITS-1:0]                 cmd_finish,
   input  logic [TIME_BITS-1:0]                 cmd_now,
   input  logic [dcf_pkg::UNIV_BITS-1:0]        universe,
   input  logic                                 rsp_pop,
   output logic                                 rsp_empty,
   output logic [dcf_pkg::CHAN_BITS-1:0]        rsp_out_channel,
   output logic [dcf_pkg::LEVEL_BITS-1:0]       rsp_out_level,
   output logic                                 rsp_fade_done,
   output logic [dcf_pkg::STATUS_BITS-1:0]      rsp_status_address
);
   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int LB = dcf_pkg::LEVEL_BITS;
   localparam int EW = 3 * LB + 2 * TIME_BITS;
   localparam logic [AW-1:0] LAST = AW'(CHANNELS - 1);

   dcf_pkg::back_state_type state_ff, state_in;
   dcf_pkg::cmd_type        cmd_ff;
   logic [TIME_BITS-1:0]    begin_ff, finish_ff, now_ff;
   logic [AW-1:0]           clr_ff, clr_in;
   logic [LB-1:0]           old_ff, goal_ff;
   logic [TIME_BITS-1:0]    s_ff, e_ff;
   logic [TIME_BITS-1:0]    d_ff, d_in, x_ff, x_in, r_ff, r_in;
   logic [LB-1:0]           a_ff, a_in, q_ff, q_in;
   logic [2:0]              bit_ff, bit_in;
   logic                    phase_ff, phase_in;
   logic [LB-1:0]           level_ff, level_in;
   logic                    done_ff, done_in;
   logic                    out_valid_ff;
   logic [dcf_pkg::CHAN_BITS-1:0]   out_chan_ff;
   logic [LB-1:0]                   out_level_ff;
   logic                            out_done_ff;
   logic [dcf_pkg::STATUS_BITS-1:0] out_status_ff;
   logic                    load_entry, load_out, out_free;
   logic                    wr_en, rd_en;
   logic [AW-1:0]           wr_addr;
   logic [EW-1:0]           wr_data, rd_data;
   logic [LB-1:0]           e_old, e_goal, e_pres;
   logic [TIME_BITS-1:0]    e_s, e_e, t_clamp;
   logic [TIME_BITS:0]      dbl, sum;
   logic [LB:0]             fall_part;

   dcf_ram #(.WIDTH(EW), .DEPTH(CHANNELS)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cmd.channel[AW-1:0]),
      .rd_data (rd_data)
   );

   assign {e_old, e_goal, e_pres, e_s, e_e} = rd_data;
   assign out_free  = !out_valid_ff || rsp_pop;
   assign clearing  = (state_ff == dcf_pkg::ST_CLEAR);
   assign t_clamp   = (now_ff < e_s) ? e_s : now_ff;
   assign dbl       = {r_ff, 1'b0};
   assign sum       = {1'b0, r_ff} + {1'b0, x_ff};
   assign fall_part = {1'b0, q_ff} + {{LB{1'b0}}, (r_ff != '0)};

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cmd_ready  = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      wr_addr    = cmd_ff.channel[AW-1:0];
      wr_data    = '0;
      load_entry = 1'b0;
      load_out   = 1'b0;
      level_in   = level_ff;
      done_in    = done_ff;
      d_in = d_ff; x_in = x_ff; r_in = r_ff; a_in = a_ff; q_in = q_ff;
      bit_in = bit_ff; phase_in = phase_ff;
      unique case (state_ff)
         dcf_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
            if (clr_ff == LAST) begin
               state_in = dcf_pkg::ST_IDLE;
            end
         end
         dcf_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_ready = 1'b1;
               if (cmd.in_range) begin
                  rd_en    = 1'b1;
                  state_in = dcf_pkg::ST_EVAL;
               end else begin
                  level_in = '0;
                  done_in  = 1'b0;
                  state_in = dcf_pkg::ST_EMIT;
               end
            end
         end
         dcf_pkg::ST_EVAL: begin
            load_entry = 1'b1;
            done_in    = 1'b0;
            if (cmd_ff.kind == dcf_pkg::KIND_WRITE) begin
               wr_en    = 1'b1;
               wr_data  = {e_old, cmd_ff.target, e_pres, begin_ff, finish_ff};
               state_in = dcf_pkg::ST_IDLE;
            end else if (e_old == e_goal) begin
               level_in = e_pres;
               state_in = dcf_pkg::ST_EMIT;
            end else if (now_ff > e_e) begin
               wr_en    = 1'b1;
               wr_data  = {e_goal, e_goal, e_goal, e_s, e_e};
               level_in = e_goal;
               done_in  = 1'b1;
               state_in = dcf_pkg::ST_EMIT;
            end else if (e_e <= e_s) begin
               wr_en    = 1'b1;
               wr_data  = {e_old, e_goal, e_old, e_s, e_e};
               level_in = e_old;
               state_in = dcf_pkg::ST_EMIT;
            end else begin
               d_in     = e_e - e_s;
               x_in     = t_clamp - e_s;
               a_in     = (e_goal > e_old) ? (e_goal - e_old) : (e_old - e_goal);
               r_in     = '0;
               q_in     = '0;
               bit_in   = 3'(dcf_pkg::DIV_STEPS - 1);
               phase_in = 1'b0;
               state_in = dcf_pkg::ST_DIV;
            end
         end
         dcf_pkg::ST_DIV: begin
            if (!phase_ff) begin
               if (dbl >= {1'b0, d_ff}) begin
                  q_in = {q_ff[LB-2:0], 1'b1};
                  r_in = TIME_BITS'(dbl - {1'b0, d_ff});
               end else begin
                  q_in = {q_ff[LB-2:0], 1'b0};
                  r_in = dbl[TIME_BITS-1:0];
               end
               phase_in = 1'b1;
            end else begin
               if (a_ff[bit_ff]) begin
                  if (sum >= {1'b0, d_ff}) begin
                     q_in = q_ff + LB'(1);
                     r_in = TIME_BITS'(sum - {1'b0, d_ff});
                  end else begin
                     r_in = sum[TIME_BITS-1:0];
                  end
               end
               phase_in = 1'b0;
               bit_in   = bit_ff - 3'd1;
               if (bit_ff == 3'd0) begin
                  state_in = dcf_pkg::ST_FIN;
               end
            end
         end
         dcf_pkg::ST_FIN: begin
            if (goal_ff > old_ff) begin
               level_in = old_ff + q_ff;
            end else begin
               level_in = old_ff - fall_part[LB-1:0];
            end
            wr_en    = 1'b1;
            wr_data  = {old_ff, goal_ff, level_in, s_ff, e_ff};
            state_in = dcf_pkg::ST_EMIT;
         end
         dcf_pkg::ST_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = dcf_pkg::ST_IDLE;
            end
         end
         default: state_in = dcf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dcf_pkg::ST_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (load_out) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_ready) begin
         cmd_ff    <= cmd;
         begin_ff  <= cmd_begin;
         finish_ff <= cmd_finish;
         now_ff    <= cmd_now;
      end
      if (load_entry) begin
         old_ff  <= e_old;
         goal_ff <= e_goal;
         s_ff    <= e_s;
         e_ff    <= e_e;
      end
      d_ff <= d_in; x_ff <= x_in; r_ff <= r_in; a_ff <= a_in; q_ff <= q_in;
      bit_ff   <= bit_in;
      phase_ff <= phase_in;
      level_ff <= level_in;
      done_ff  <= done_in;
      if (load_out) begin
         out_chan_ff   <= cmd_ff.channel;
         out_level_ff  <= level_ff;
         out_done_ff   <= done_ff;
         out_status_ff <= dcf_pkg::STATUS_BITS'({universe, cmd_ff.channel})
                          + dcf_pkg::STATUS_BITS'(1);
      end
   end

   assign rsp_empty          = !out_valid_ff;
   assign rsp_out_channel    = out_chan_ff;
   assign rsp_out_level      = out_level_ff;
   assign rsp_fade_done      = out_done_ff;
   assign rsp_status_address = out_status_ff;
endmodule

>>> hdl/dmx_channel_crossfade.sv
// Top level of the per-channel linear crossfade engine.
// Depends on dcf_pkg, dcf_front, dcf_back and the assertion header.
//
// Usage:
//  - Request queue: req_push / req_full. A write word (kind 0) stores a
//    channel's target level and fade window; an evaluate word (kind 1)
//    returns one result word with the channel's level at req_now_time.
//  - Result queue: rsp_empty / rsp_pop. The oldest result sits on the
//    rsp_ ports while rsp_empty is low.
//  - csr_valid / csr_ready write universe_id; csr_ready is always high.
//  - A two-word queue separates the front end from the evaluation
//    sequencer, so requests are taken while a result waits to be popped.
//  - Sequencing: a write passes through a RAM read and a RAM write in the
//    sequencer; a hold, settle or empty-window evaluation reads the entry,
//    evaluates it and then emits its result; a fade in progress first runs
//    the 8-bit restoring divider, which takes a doubling step and an add
//    step per quotient bit. The result word is registered onto the rsp_
//    ports when the emit state finds the output word free.
//  - Reset: synchronous; the channel RAM is then cleared one entry a cycle,
//    through all CHANNELS entries, with req_full high.
//  - A stalled result holds the sequencer once its output word is full;
//    the request queue then fills and raises req_full.
`include "dmx_channel_crossfade_assert.svh"
module dmx_channel_crossfade #(
   parameter int CHANNELS  = 512,
   parameter int TIME_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_kind,
   input  logic [dcf_pkg::CHAN_BITS-1:0]        req_channel,
   input  logic [dcf_pkg::LEVEL_BITS-1:0]       req_target_level,
   input  logic [dcf_pkg::PORT_TIME_BITS-1:0]   req_fade_begin,
   input  logic [dcf_pkg::PORT_TIME_BITS-1:0]   req_fade_finish,
   input  logic [dcf_pkg::PORT_TIME_BITS-1:0]   req_now_time,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic [dcf_pkg::CHAN_BITS-1:0]        rsp_out_channel,
   output logic [dcf_pkg::LEVEL_BITS-1:0]       rsp_out_level,
   output logic                                 rsp_fade_done,
   output logic [dcf_pkg::STATUS_BITS-1:0]      rsp_status_address,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dcf_pkg::UNIV_BITS-1:0]        csr_wdata
);
   logic [dcf_pkg::UNIV_BITS-1:0] universe_ff;
   logic                          clearing, cmd_valid, cmd_ready;
   dcf_pkg::cmd_type              cmd;
   logic [TIME_BITS-1:0]          cmd_begin, cmd_finish, cmd_now;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         universe_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         universe_ff <= csr_wdata;
      end
   end

   dcf_front #(.CHANNELS(CHANNELS), .TIME_BITS(TIME_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .clearing         (clearing),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_kind         (req_kind),
      .req_channel      (req_channel),
      .req_target_level (req_target_level),
      .req_fade_begin   (req_fade_begin),
      .req_fade_finish  (req_fade_finish),
      .req_now_time     (req_now_time),
      .cmd_valid        (cmd_valid),
      .cmd_ready        (cmd_ready),
      .cmd              (cmd),
      .cmd_begin        (cmd_begin),
      .cmd_finish       (cmd_finish),
      .cmd_now          (cmd_now)
   );

   dcf_back #(.CHANNELS(CHANNELS), .TIME_BITS(TIME_BITS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .clearing           (clearing),
      .cmd_valid          (cmd_valid),
      .cmd_ready          (cmd_ready),
      .cmd                (cmd),
      .cmd_begin          (cmd_begin),
      .cmd_finish         (cmd_finish),
      .cmd_now            (cmd_now),
      .universe           (universe_ff),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_out_channel    (rsp_out_channel),
      .rsp_out_level      (rsp_out_level),
      .rsp_fade_done      (rsp_fade_done),
      .rsp_status_address (rsp_status_address)
   );

   `DCF_ASSERT(a_no_req_while_clear, clock, reset, clearing |-> req_full, "request taken during clear")
   `DCF_ASSERT(a_no_rsp_while_clear, clock, reset, clearing |-> rsp_empty, "result during clear")
   `DCF_ASSERT(a_done_in_range, clock, reset, (!rsp_empty && rsp_fade_done) |-> ({1'b0, rsp_out_channel} < 10'(CHANNELS)), "done on bad channel")
   `DCF_ASSERT(a_status_addr, clock, reset, !rsp_empty |-> (rsp_status_address == dcf_pkg::STATUS_BITS'({universe_ff, rsp_out_channel}) + dcf_pkg::STATUS_BITS'(1)), "bad status address")
endmodule
